// ----- hdl/bbcmd_pkg.sv -----
// Shared types and constants for the battery board command slave:
// item structs, command codes, status flag positions and the telemetry table.
// No dependencies.
package bbcmd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  returned_len;
  } out_item_t;

  typedef struct packed {
    logic [15:0] version_word;
    logic [15:0] checksum_word;
    logic [15:0] brownout_count;
    logic [15:0] soft_reset_count;
    logic [15:0] last_error_code;
  } cfg_regs_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VERSION   = 3'd0,
    CFG_CHECKSUM  = 3'd1,
    CFG_BROWNOUT  = 3'd2,
    CFG_SOFT_RST  = 3'd3,
    CFG_LAST_ERR  = 3'd4
  } cfg_index_t;

  localparam logic [15:0] VERSION_RESET  = 16'h1001;
  localparam logic [15:0] CHECKSUM_RESET = 16'hBEEF;

  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] CMD_STATUS      = 8'h01;
  localparam logic [7:0] CMD_LAST_ERR    = 8'h03;
  localparam logic [7:0] CMD_VERSION     = 8'h04;
  localparam logic [7:0] CMD_CHECKSUM    = 8'h05;
  localparam logic [7:0] CMD_TELEMETRY   = 8'h10;
  localparam logic [7:0] CMD_BROWNOUT    = 8'h31;
  localparam logic [7:0] CMD_SOFT_RST    = 8'h32;
  localparam logic [7:0] CMD_MANUAL_CNT  = 8'h33;
  localparam logic [7:0] CMD_MANUAL_RST  = 8'h80;
  localparam logic [7:0] CMD_HEATER_GET  = 8'h90;
  localparam logic [7:0] CMD_HEATER_SET  = 8'h91;

  localparam logic [7:0] LEN_SHORT   = 8'd2;
  localparam logic [7:0] LEN_LONG    = 8'd3;
  localparam logic [7:0] LEN_BAD_ACK = 8'd2;

  localparam logic [15:0] ALL_ONES = 16'hFFFF;

  localparam int unsigned FLAG_W          = 4;
  localparam int unsigned FLAG_UNKNOWN_BIT = 0;
  localparam int unsigned FLAG_BADARG_BIT  = 2;
  localparam int unsigned FLAG_BADCHAN_BIT = 3;

  localparam int unsigned TLM_TABLE_SIZE = 16;

  localparam logic [15:0] TLM_CODE [TLM_TABLE_SIZE] = '{
    16'hE280, 16'hE284, 16'hE28E, 16'hE308,
    16'hE214, 16'hE210, 16'hE204, 16'hE200,
    16'hE398, 16'hE39F, 16'hE3A8, 16'hE3AF,
    16'hE3B8, 16'hE3BF, 16'hE3C8, 16'hE3CF
  };

  localparam logic [15:0] TLM_VALUE [TLM_TABLE_SIZE] = '{
    16'd918, 16'd81,  16'd700, 16'd790,
    16'd757, 16'd852, 16'd753, 16'd765,
    16'd795, 16'd680, 16'd790, 16'd400,
    16'd780, 16'd450, 16'd786, 16'd530
  };

endpackage

// ----- hdl/bbcmd_cfg_regs.sv -----
// Configuration register file of the battery board command slave.
// Depends on bbcmd_pkg for the register struct and index codes.
module bbcmd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bbcmd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bbcmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bbcmd_pkg::cfg_regs_t                regs
);

  bbcmd_pkg::cfg_regs_t regs_r;
  bbcmd_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (bbcmd_pkg::cfg_index_t'(cfg_addr))
        bbcmd_pkg::CFG_VERSION:  regs_nxt.version_word     = cfg_wdata;
        bbcmd_pkg::CFG_CHECKSUM: regs_nxt.checksum_word    = cfg_wdata;
        bbcmd_pkg::CFG_BROWNOUT: regs_nxt.brownout_count   = cfg_wdata;
        bbcmd_pkg::CFG_SOFT_RST: regs_nxt.soft_reset_count = cfg_wdata;
        bbcmd_pkg::CFG_LAST_ERR: regs_nxt.last_error_code  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.version_word     <= bbcmd_pkg::VERSION_RESET;
      regs_r.checksum_word    <= bbcmd_pkg::CHECKSUM_RESET;
      regs_r.brownout_count   <= '0;
      regs_r.soft_reset_count <= '0;
      regs_r.last_error_code  <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ----- hdl/bbcmd_core.sv -----
// Command decode and board state (response word, flags, heater, manual resets).
// Depends on bbcmd_pkg for item structs, command codes and the telemetry table.
module bbcmd_core #(
  parameter int unsigned TELEMETRY_CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_en,
  input  bbcmd_pkg::in_item_t   item,
  input  bbcmd_pkg::cfg_regs_t  regs,
  output bbcmd_pkg::out_item_t  result
);

  logic [15:0]                   resp_r, resp_nxt;
  logic [bbcmd_pkg::FLAG_W-1:0]  flags_r, flags_nxt;
  logic                          heater_r, heater_nxt;
  logic [15:0]                   mrc_r, mrc_nxt;
  logic [bbcmd_pkg::FLAG_W-1:0]  flags_ok;
  logic [15:0]                   chan_code;
  logic                          chan_hit;
  logic [15:0]                   chan_val;

  assign chan_code = {item.byte1, item.byte2};

  always_comb begin
    chan_hit = 1'b0;
    chan_val = '0;
    for (int i = 0; i < bbcmd_pkg::TLM_TABLE_SIZE; i++) begin
      if ((i < TELEMETRY_CHANNELS) && (chan_code == bbcmd_pkg::TLM_CODE[i])) begin
        chan_hit = 1'b1;
        chan_val = chan_val | bbcmd_pkg::TLM_VALUE[i];
      end
    end
  end

  always_comb begin
    flags_ok = flags_r;
    flags_ok[bbcmd_pkg::FLAG_UNKNOWN_BIT] = 1'b0;
    flags_ok[bbcmd_pkg::FLAG_BADARG_BIT]  = 1'b0;
  end

  always_comb begin
    resp_nxt   = resp_r;
    flags_nxt  = flags_r;
    heater_nxt = heater_r;
    mrc_nxt    = mrc_r;
    result.read_data    = '0;
    result.returned_len = item.length;
    if (item.kind == bbcmd_pkg::KIND_READ) begin
      result.read_data = resp_r;
    end else if (item.length != bbcmd_pkg::LEN_SHORT && item.length != bbcmd_pkg::LEN_LONG) begin
      resp_nxt = bbcmd_pkg::ALL_ONES;
      result.returned_len = bbcmd_pkg::LEN_BAD_ACK;
    end else begin
      case (item.byte0) inside
        bbcmd_pkg::CMD_TELEMETRY: begin
          if (item.length != bbcmd_pkg::LEN_LONG) begin
            flags_nxt[bbcmd_pkg::FLAG_BADARG_BIT] = 1'b1;
            resp_nxt = bbcmd_pkg::ALL_ONES;
          end else begin
            flags_nxt = flags_ok;
            flags_nxt[bbcmd_pkg::FLAG_BADCHAN_BIT] = ~chan_hit;
            resp_nxt = chan_hit ? chan_val : bbcmd_pkg::ALL_ONES;
          end
        end
        bbcmd_pkg::CMD_HEATER_SET: begin
          if (item.length != bbcmd_pkg::LEN_SHORT) begin
            flags_nxt[bbcmd_pkg::FLAG_BADARG_BIT] = 1'b1;
            resp_nxt = bbcmd_pkg::ALL_ONES;
          end else begin
            flags_nxt = flags_ok;
            if (item.byte1[7:1] != '0) begin
              resp_nxt = bbcmd_pkg::ALL_ONES;
            end else begin
              heater_nxt = item.byte1[0];
              resp_nxt   = '0;
            end
          end
        end
        bbcmd_pkg::CMD_STATUS, bbcmd_pkg::CMD_LAST_ERR, bbcmd_pkg::CMD_VERSION,
        bbcmd_pkg::CMD_CHECKSUM, bbcmd_pkg::CMD_BROWNOUT, bbcmd_pkg::CMD_SOFT_RST,
        bbcmd_pkg::CMD_MANUAL_CNT, bbcmd_pkg::CMD_HEATER_GET,
        bbcmd_pkg::CMD_MANUAL_RST: begin
          if (item.byte1 != '0) begin
            flags_nxt[bbcmd_pkg::FLAG_BADARG_BIT] = 1'b1;
            resp_nxt = bbcmd_pkg::ALL_ONES;
          end else begin
            flags_nxt = flags_ok;
            case (item.byte0)
              bbcmd_pkg::CMD_STATUS:     resp_nxt = {12'd0, flags_ok};
              bbcmd_pkg::CMD_LAST_ERR:   resp_nxt = regs.last_error_code;
              bbcmd_pkg::CMD_VERSION:    resp_nxt = regs.version_word;
              bbcmd_pkg::CMD_CHECKSUM:   resp_nxt = regs.checksum_word;
              bbcmd_pkg::CMD_BROWNOUT:   resp_nxt = regs.brownout_count;
              bbcmd_pkg::CMD_SOFT_RST:   resp_nxt = regs.soft_reset_count;
              bbcmd_pkg::CMD_MANUAL_CNT: resp_nxt = mrc_r;
              bbcmd_pkg::CMD_HEATER_GET: resp_nxt = {15'd0, heater_r};
              default: begin
                mrc_nxt  = mrc_r + 16'd1;
                resp_nxt = '0;
              end
            endcase
          end
        end
        default: begin
          flags_nxt[bbcmd_pkg::FLAG_UNKNOWN_BIT] = 1'b1;
          resp_nxt = bbcmd_pkg::ALL_ONES;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r   <= '0;
      flags_r  <= '0;
      heater_r <= 1'b1;
      mrc_r    <= '0;
    end else if (item_en) begin
      resp_r   <= resp_nxt;
      flags_r  <= flags_nxt;
      heater_r <= heater_nxt;
      mrc_r    <= mrc_nxt;
    end
  end

endmodule

// ----- hdl/battery_board_i2c_command_slave.sv -----
// Battery board I2C command slave. One item is one bus access; one result item
// comes back for each. Takes one item per cycle while out_ready is high; an
// accepted item waits in the input register, then is decoded into the result
// register once that is free. The single decode stage updates the board state
// as each item passes, so items are handled strictly in order with no gap
// between them. With out_ready low the two registers fill and in_ready drops.
// Depends on bbcmd_pkg, bbcmd_cfg_regs and bbcmd_core.
module battery_board_i2c_command_slave #(
  parameter int unsigned TELEMETRY_CHANNELS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bbcmd_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bbcmd_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [bbcmd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bbcmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bbcmd_pkg::cfg_regs_t  regs;
  bbcmd_pkg::in_item_t   s1_item_r;
  logic                  s1_valid_r, s1_valid_nxt;
  bbcmd_pkg::out_item_t  out_item_r;
  bbcmd_pkg::out_item_t  result;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;

  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;
  assign in_take  = in_valid & in_ready;

  always_comb begin
    s1_valid_nxt  = in_take | (s1_valid_r & ~out_free);
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  bbcmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  bbcmd_core #(
    .TELEMETRY_CHANNELS (TELEMETRY_CHANNELS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (s1_adv),
    .item    (s1_item_r),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
